### rtl/ckb_pkg.sv
// ckb_pkg: shared types, constants and helpers of the ycbcr chroma key blend core
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps

package ckb_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int Q12_SHIFT   = 12;
    localparam int ALPHA_SHIFT = 20;

    localparam logic [7:0]  CHROMA_MID = 8'd128;
    localparam logic [7:0]  PIX_MAX    = 8'd255;
    localparam logic [12:0] SUP_MAX    = 13'd4096;

    localparam logic [20:0] RST_KEY_OFFSET  = 21'd550000;
    localparam logic [13:0] RST_KEY_COS     = 14'd0;
    localparam logic [13:0] RST_KEY_SIN     = 14'd0;
    localparam logic [15:0] RST_WEDGE_SLOPE = 16'd4096;
    localparam logic [15:0] RST_ALPHA_GAIN  = 16'd2176;
    localparam logic [12:0] RST_SPILL_GAIN  = 13'd0;
    localparam logic [17:0] RST_KEY_CHROMA  = 18'd0;
    localparam logic        RST_MASK_MODE   = 1'b0;

    typedef enum logic [2:0] {
        CFG_KEY_OFFSET  = 3'd0,
        CFG_KEY_COS     = 3'd1,
        CFG_KEY_SIN     = 3'd2,
        CFG_WEDGE_SLOPE = 3'd3,
        CFG_ALPHA_GAIN  = 3'd4,
        CFG_SPILL_GAIN  = 3'd5,
        CFG_KEY_CHROMA  = 3'd6,
        CFG_MASK_MODE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [20:0] key_offset;
        logic signed [13:0] key_cos;
        logic signed [13:0] key_sin;
        logic [15:0]        wedge_slope;
        logic [15:0]        alpha_gain;
        logic [12:0]        spill_gain;
        logic [17:0]        key_chroma;
        logic               mask_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] fg_luma;
        logic [7:0] fg_cb;
        logic [7:0] fg_cr;
        logic [7:0] bg_luma;
        logic [7:0] bg_cb;
        logic [7:0] bg_cr;
    } t_pix;

    typedef enum logic [1:0] {
        KIND_MASK  = 2'd0,
        KIND_BG    = 2'd1,
        KIND_BLEND = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] alpha;
        t_pix       pix;
    } t_qent;

    // divide-by-255 approximation of a*alpha + b*(255-alpha)
    function automatic logic [7:0] ckb_blend(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] alpha);
        logic [16:0] pa;
        logic [16:0] pb;
        logic [16:0] x;
        logic [16:0] r;
        pa = 17'(a) * 17'(alpha);
        pb = 17'(b) * 17'(PIX_MAX - alpha);
        x  = pa + pb;
        r  = x + 17'd1 + (x >> 8);
        return r[15:8];
    endfunction

endpackage

### rtl/ckb_in_if.sv
// ckb_in_if: input channel of the chroma key blend core, foreground and background pixel
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps

interface ckb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] fg_luma;
    logic [7:0] fg_blue_diff;
    logic [7:0] fg_red_diff;
    logic [7:0] bg_luma;
    logic [7:0] bg_blue_diff;
    logic [7:0] bg_red_diff;

    modport source (
        output valid, fg_luma, fg_blue_diff, fg_red_diff, bg_luma, bg_blue_diff, bg_red_diff,
        input  ready
    );
    modport sink (
        input  valid, fg_luma, fg_blue_diff, fg_red_diff, bg_luma, bg_blue_diff, bg_red_diff,
        output ready
    );
endinterface

### rtl/ckb_out_if.sv
// ckb_out_if: output channel of the chroma key blend core, one result pixel
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps

interface ckb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_luma;
    logic [7:0] out_blue_diff;
    logic [7:0] out_red_diff;

    modport source (
        output valid, out_luma, out_blue_diff, out_red_diff,
        input  ready
    );
    modport sink (
        input  valid, out_luma, out_blue_diff, out_red_diff,
        output ready
    );
endinterface

### rtl/ckb_front.sv
// ckb_front: three-stage pipeline that rotates chroma, forms the wedge distance and alpha,
// removes spill and classifies each item for the queue; depends on ckb_pkg, ckb_in_if
`timescale 1ns / 1ps

module ckb_front
    import ckb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    ckb_in_if.sink      i_pix,
    input  logic        i_q_full,
    output logic        o_push,
    output t_qent       o_entry
);

    // stage valids
    logic r_a_valid, r_b_valid, r_c_valid;
    logic rdy_a, rdy_b, rdy_c;
    logic in_acc;

    // stage a: rotation
    logic signed [7:0]  uc, vc;
    logic signed [21:0] p_uc_cos, p_vc_sin, p_vc_cos, p_uc_sin;
    logic signed [23:0] xs, ys;
    logic signed [11:0] yy;
    logic [11:0]        ayy_full;
    t_pix               pix_in;
    logic signed [11:0] r_a_xx;
    logic [9:0]         r_a_ayy;
    t_pix               r_a_pix;

    // stage b: distance and spill amount
    logic [25:0]        p_slope;
    logic signed [27:0] wedge_dist;
    logic               xx_pos;
    logic [22:0]        p_sup;
    logic [12:0]        sup;
    logic signed [27:0] r_b_dist;
    logic [12:0]        r_b_sup;
    t_pix               r_b_pix;

    // stage c: alpha product and spill products
    logic signed [44:0] p_alpha;
    logic signed [8:0]  ut, vt;
    logic signed [22:0] p_cb, p_cr;
    logic signed [24:0] r_c_alpha;
    logic signed [10:0] r_c_cb_sh, r_c_cr_sh;
    t_pix               r_c_pix;

    // classify
    logic               alpha_le0, alpha_big;
    logic [7:0]         alpha8;
    logic signed [11:0] cb_t, cr_t;
    logic [7:0]         cb_new, cr_new;

    assign rdy_c  = !r_c_valid || !i_q_full;
    assign rdy_b  = !r_b_valid || rdy_c;
    assign rdy_a  = !r_a_valid || rdy_b;
    assign i_pix.ready = rdy_a;
    assign in_acc = i_pix.valid && rdy_a;
    assign o_push = r_c_valid && !i_q_full;

    assign pix_in = '{fg_luma: i_pix.fg_luma, fg_cb: i_pix.fg_blue_diff,
                      fg_cr: i_pix.fg_red_diff, bg_luma: i_pix.bg_luma,
                      bg_cb: i_pix.bg_blue_diff, bg_cr: i_pix.bg_red_diff};

    assign uc       = $signed(i_pix.fg_blue_diff ^ CHROMA_MID);
    assign vc       = $signed(i_pix.fg_red_diff ^ CHROMA_MID);
    assign p_uc_cos = uc * i_cfg.key_cos;
    assign p_vc_sin = vc * i_cfg.key_sin;
    assign p_vc_cos = vc * i_cfg.key_cos;
    assign p_uc_sin = uc * i_cfg.key_sin;
    assign xs = {{2{p_uc_cos[21]}}, p_uc_cos} + {{2{p_vc_sin[21]}}, p_vc_sin};
    assign ys = {{2{p_vc_cos[21]}}, p_vc_cos} - {{2{p_uc_sin[21]}}, p_uc_sin};
    assign yy = ys[Q12_SHIFT +: 12];
    assign ayy_full = yy[11] ? (12'd0 - yy) : yy;

    assign p_slope = r_a_ayy * i_cfg.wedge_slope;
    assign wedge_dist = {{7{i_cfg.key_offset[20]}}, i_cfg.key_offset}
                      - {{4{r_a_xx[11]}}, r_a_xx, 12'd0}
                      + {2'd0, p_slope};
    assign xx_pos = !r_a_xx[11] && (r_a_xx != 12'sd0);
    assign p_sup  = r_a_xx[9:0] * i_cfg.spill_gain;
    assign sup    = !xx_pos ? 13'd0 : ((p_sup > 23'(SUP_MAX)) ? SUP_MAX : p_sup[12:0]);

    assign p_alpha = r_b_dist * $signed({1'b0, i_cfg.alpha_gain});
    assign ut      = $signed(i_cfg.key_chroma[17:9]);
    assign vt      = $signed(i_cfg.key_chroma[8:0]);
    assign p_cb    = $signed({1'b0, r_b_sup}) * ut;
    assign p_cr    = $signed({1'b0, r_b_sup}) * vt;

    assign alpha_le0 = r_c_alpha[24] || (r_c_alpha == 25'sd0);
    assign alpha_big = !r_c_alpha[24] && (|r_c_alpha[23:8]);
    assign alpha8    = alpha_le0 ? 8'd0 : (alpha_big ? PIX_MAX : r_c_alpha[7:0]);

    assign cb_t = $signed({4'd0, r_c_pix.fg_cb}) - $signed({r_c_cb_sh[10], r_c_cb_sh});
    assign cr_t = $signed({4'd0, r_c_pix.fg_cr}) - $signed({r_c_cr_sh[10], r_c_cr_sh});
    assign cb_new = cb_t[11] ? 8'd0 : ((|cb_t[10:8]) ? PIX_MAX : cb_t[7:0]);
    assign cr_new = cr_t[11] ? 8'd0 : ((|cr_t[10:8]) ? PIX_MAX : cr_t[7:0]);

    always_comb begin
        o_entry           = '0;
        o_entry.alpha     = alpha8;
        o_entry.pix       = r_c_pix;
        o_entry.pix.fg_cb = cb_new;
        o_entry.pix.fg_cr = cr_new;
        priority if (i_cfg.mask_mode) begin
            o_entry.kind = KIND_MASK;
        end else if (alpha_le0) begin
            o_entry.kind = KIND_BG;
        end else begin
            o_entry.kind = KIND_BLEND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_pix.valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_xx  <= xs[Q12_SHIFT +: 12];
            r_a_ayy <= ayy_full[9:0];
            r_a_pix <= pix_in;
        end
        if (rdy_b && r_a_valid) begin
            r_b_dist <= wedge_dist;
            r_b_sup  <= sup;
            r_b_pix  <= r_a_pix;
        end
        if (rdy_c && r_b_valid) begin
            r_c_alpha <= p_alpha[ALPHA_SHIFT +: 25];
            r_c_cb_sh <= p_cb[Q12_SHIFT +: 11];
            r_c_cr_sh <= p_cr[Q12_SHIFT +: 11];
            r_c_pix   <= r_b_pix;
        end
    end

endmodule

### rtl/ckb_fifo.sv
// ckb_fifo: short queue of classified items between the front pipeline and the blend stage
// depends on ckb_pkg
`timescale 1ns / 1ps

module ckb_fifo
    import ckb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_wr_data,
    input  logic  i_pop,
    output t_qent o_rd_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_qent            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/ckb_back.sv
// ckb_back: takes classified items from the queue, blends or selects, holds the output register
// depends on ckb_pkg, ckb_out_if
`timescale 1ns / 1ps

module ckb_back
    import ckb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qent      i_entry,
    input  logic       i_empty,
    output logic       o_pop,
    ckb_out_if.source  o_pix
);

    logic       r_valid;
    logic [7:0] r_luma, r_cb, r_cr;
    logic [7:0] n_luma, n_cb, n_cr;

    assign o_pop = !i_empty && (!r_valid || o_pix.ready);

    always_comb begin
        unique case (i_entry.kind)
            KIND_MASK: begin
                n_luma = i_entry.alpha;
                n_cb   = CHROMA_MID;
                n_cr   = CHROMA_MID;
            end
            KIND_BLEND: begin
                n_luma = ckb_blend(i_entry.pix.fg_luma, i_entry.pix.bg_luma, i_entry.alpha);
                n_cb   = ckb_blend(i_entry.pix.fg_cb, i_entry.pix.bg_cb, i_entry.alpha);
                n_cr   = ckb_blend(i_entry.pix.fg_cr, i_entry.pix.bg_cr, i_entry.alpha);
            end
            default: begin
                n_luma = i_entry.pix.bg_luma;
                n_cb   = i_entry.pix.bg_cb;
                n_cr   = i_entry.pix.bg_cr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_luma <= n_luma;
            r_cb   <= n_cb;
            r_cr   <= n_cr;
        end
    end

    assign o_pix.valid         = r_valid;
    assign o_pix.out_luma      = r_luma;
    assign o_pix.out_blue_diff = r_cb;
    assign o_pix.out_red_diff  = r_cr;

endmodule

### rtl/ycbcr_chroma_key_blend_core.sv
// ycbcr_chroma_key_blend_core: chroma key and alpha blend of a foreground over a background
// depends on ckb_pkg, ckb_in_if, ckb_out_if, ckb_front, ckb_fifo, ckb_back
//
// usage
// - i_pix carries one item per handshake: a foreground and a background YCbCr pixel
// - o_pix carries one result pixel per item, in order; in mask mode luma holds alpha
//   and both chroma samples are 128
// - setup is written through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle;
//   software computes the fixed-point key registers once per frame
// - one item per cycle sustained while the receiver keeps up; the front pipeline
//   has three register stages (rotation, wedge distance, alpha product) and the
//   blend stage one output register; an accepted item passes these stages, the
//   queue and the output register in order
// - when the receiver stalls, results collect in the output register and the queue of
//   QUEUE_DEPTH entries; once it is full the front stalls and i_pix.ready falls
// - reset loads the default key registers and empties pipeline, queue and output
`timescale 1ns / 1ps

module ycbcr_chroma_key_blend_core
    import ckb_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ckb_in_if.sink                i_pix,
    ckb_out_if.source             o_pix
);

    t_cfg  r_cfg;
    t_qent fr_entry, q_head;
    logic  fr_push, q_full, q_empty, bk_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_offset  <= $signed(RST_KEY_OFFSET);
            r_cfg.key_cos     <= $signed(RST_KEY_COS);
            r_cfg.key_sin     <= $signed(RST_KEY_SIN);
            r_cfg.wedge_slope <= RST_WEDGE_SLOPE;
            r_cfg.alpha_gain  <= RST_ALPHA_GAIN;
            r_cfg.spill_gain  <= RST_SPILL_GAIN;
            r_cfg.key_chroma  <= RST_KEY_CHROMA;
            r_cfg.mask_mode   <= RST_MASK_MODE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_OFFSET:  r_cfg.key_offset  <= $signed(i_cfg_data[20:0]);
                CFG_KEY_COS:     r_cfg.key_cos     <= $signed(i_cfg_data[13:0]);
                CFG_KEY_SIN:     r_cfg.key_sin     <= $signed(i_cfg_data[13:0]);
                CFG_WEDGE_SLOPE: r_cfg.wedge_slope <= i_cfg_data[15:0];
                CFG_ALPHA_GAIN:  r_cfg.alpha_gain  <= i_cfg_data[15:0];
                CFG_SPILL_GAIN:  r_cfg.spill_gain  <= i_cfg_data[12:0];
                CFG_KEY_CHROMA:  r_cfg.key_chroma  <= i_cfg_data[17:0];
                CFG_MASK_MODE:   r_cfg.mask_mode   <= i_cfg_data[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    ckb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (fr_push),
        .o_entry  (fr_entry)
    );

    ckb_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (fr_push),
        .i_wr_data (fr_entry),
        .i_pop     (bk_pop),
        .o_rd_data (q_head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    ckb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_head),
        .i_empty (q_empty),
        .o_pop   (bk_pop),
        .o_pix   (o_pix)
    );

endmodule

### tb/sv/ycbcr_chroma_key_blend_core_tb.sv
// ycbcr_chroma_key_blend_core_tb: self-checking bench for the chroma key blend core
// uses ckb_pkg and the ckb_in_if / ckb_out_if channels; a scoreboard class predicts each pixel
// directed key settings first, then randomised key scenes under varying handshake pressure
`timescale 1ns / 1ps

module ycbcr_chroma_key_blend_core_tb;
    import ckb_pkg::*;

    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     MAX_REPORTS  = 10;
    localparam int     SCENES       = 6;
    localparam int     SCENE_ITEMS  = 90;
    localparam int     HOLD_CYCLES  = 200;
    localparam longint LUMA_MAX     = longint'(PIX_MAX);
    localparam longint SPILL_CAP    = longint'(SUP_MAX);
    localparam longint CHROMA_ZERO  = longint'(CHROMA_MID);
    localparam longint UNIT_Q12     = longint'(1) << Q12_SHIFT;

    localparam t_cfg RESET_CFG = '{
        key_offset:  RST_KEY_OFFSET,
        key_cos:     RST_KEY_COS,
        key_sin:     RST_KEY_SIN,
        wedge_slope: RST_WEDGE_SLOPE,
        alpha_gain:  RST_ALPHA_GAIN,
        spill_gain:  RST_SPILL_GAIN,
        key_chroma:  RST_KEY_CHROMA,
        mask_mode:   RST_MASK_MODE
    };

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] blue;
        logic [7:0] red;
    } t_out_px;

    class key_blend_model;
        t_cfg    regs;
        t_out_px expected[$];
        int      mismatches;
        int      n_items;
        int      n_mask;
        int      n_bg;
        int      n_blend;
        int      n_spill;

        function new();
            regs = RESET_CFG;
        endfunction

        function logic [7:0] sat8(longint v);
            return (v < 0) ? 8'd0 : ((v > LUMA_MAX) ? PIX_MAX : 8'(v));
        endfunction

        // divide-by-255 approximation
        function logic [7:0] mix_channel(longint a, longint b, longint alpha);
            longint x;
            x = a * alpha + b * (LUMA_MAX - alpha);
            return 8'((x + 1 + (x >>> 8)) >>> 8);
        endfunction

        function void note_pixel(t_pix p);
            longint  uc;
            longint  vc;
            longint  kc;
            longint  ks;
            longint  xx;
            longint  yy;
            longint  wedge_dist;
            longint  alpha;
            longint  sup;
            longint  cb;
            longint  cr;
            t_out_px want;
            uc = longint'(p.fg_cb) - CHROMA_ZERO;
            vc = longint'(p.fg_cr) - CHROMA_ZERO;
            kc = longint'($signed(regs.key_cos));
            ks = longint'($signed(regs.key_sin));
            xx = (uc * kc + vc * ks) >>> Q12_SHIFT;
            yy = (vc * kc - uc * ks) >>> Q12_SHIFT;
            if (yy < 0) begin
                yy = -yy;
            end
            wedge_dist = longint'($signed(regs.key_offset)) - xx * UNIT_Q12
                       + yy * longint'(regs.wedge_slope);
            alpha = (wedge_dist * longint'(regs.alpha_gain)) >>> ALPHA_SHIFT;
            n_items++;
            if (regs.mask_mode) begin
                want = '{sat8(alpha), CHROMA_MID, CHROMA_MID};
                n_mask++;
            end else if (alpha <= 0) begin
                want = '{p.bg_luma, p.bg_cb, p.bg_cr};
                n_bg++;
            end else begin
                if (alpha > LUMA_MAX) begin
                    alpha = LUMA_MAX;
                end
                cb = longint'(p.fg_cb);
                cr = longint'(p.fg_cr);
                // spill removal along the key colour
                if (xx > 0) begin
                    sup = xx * longint'(regs.spill_gain);
                    if (sup > SPILL_CAP) begin
                        sup = SPILL_CAP;
                    end
                    cb = sat8(cb - ((sup * longint'($signed(regs.key_chroma[17:9])))
                                    >>> Q12_SHIFT));
                    cr = sat8(cr - ((sup * longint'($signed(regs.key_chroma[8:0])))
                                    >>> Q12_SHIFT));
                    n_spill++;
                end
                want = '{mix_channel(longint'(p.fg_luma), longint'(p.bg_luma), alpha),
                         mix_channel(cb, longint'(p.bg_cb), alpha),
                         mix_channel(cr, longint'(p.bg_cr), alpha)};
                n_blend++;
            end
            expected.push_back(want);
        endfunction

        function void check_pixel(logic [7:0] luma, logic [7:0] blue, logic [7:0] red);
            t_out_px want;
            if (expected.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result item: y %0d cb %0d cr %0d", luma, blue, red);
                end
                mismatches++;
                return;
            end
            want = expected.pop_front();
            if (luma !== want.luma || blue !== want.blue || red !== want.red) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("mismatch: expected y %0d cb %0d cr %0d, got y %0d cb %0d cr %0d",
                             want.luma, want.blue, want.red, luma, blue, red);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int             tx_idle_pct = 30;
    int             rx_idle_pct = 73;
    int             rx_hold     = 0;
    int             settings    = 0;
    key_blend_model model       = new();

    ckb_in_if  in_ch();
    ckb_out_if out_ch();

    ycbcr_chroma_key_blend_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (in_ch),
        .o_pix      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic send_pixel(input t_pix p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.fg_luma      <= p.fg_luma;
        in_ch.fg_blue_diff <= p.fg_cb;
        in_ch.fg_red_diff  <= p.fg_cr;
        in_ch.bg_luma      <= p.bg_luma;
        in_ch.bg_blue_diff <= p.bg_cb;
        in_ch.bg_red_diff  <= p.bg_cr;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        model.note_pixel(p);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (model.expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_setting(input t_cfg c);
        logic [CFG_DATA_W-1:0] value;
        for (int i = int'(CFG_KEY_OFFSET); i <= int'(CFG_MASK_MODE); i++) begin
            case (t_cfg_idx'(i))
                CFG_KEY_OFFSET:  value = c.key_offset;
                CFG_KEY_COS:     value = CFG_DATA_W'(c.key_cos);
                CFG_KEY_SIN:     value = CFG_DATA_W'(c.key_sin);
                CFG_WEDGE_SLOPE: value = CFG_DATA_W'(c.wedge_slope);
                CFG_ALPHA_GAIN:  value = CFG_DATA_W'(c.alpha_gain);
                CFG_SPILL_GAIN:  value = CFG_DATA_W'(c.spill_gain);
                CFG_KEY_CHROMA:  value = CFG_DATA_W'(c.key_chroma);
                CFG_MASK_MODE:   value = CFG_DATA_W'(c.mask_mode);
                default:         value = '0;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= value;
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        model.regs = c;
        settings++;
    endtask

    initial begin : receiver
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                model.check_pixel(out_ch.out_luma, out_ch.out_blue_diff, out_ch.out_red_diff);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        t_cfg c;
        t_pix p;
        int   ku;
        int   kv;
        int   phase;
        int   n;
        real  mag;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_KEY_OFFSET;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.fg_luma      <= '0;
        in_ch.fg_blue_diff <= '0;
        in_ch.fg_red_diff  <= '0;
        in_ch.bg_luma      <= '0;
        in_ch.bg_blue_diff <= '0;
        in_ch.bg_red_diff  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key settings, field extremes
        send_pixel(t_pix'(48'h00_00_00_00_00_00));
        send_pixel(t_pix'(48'hff_ff_ff_ff_ff_ff));
        send_pixel(t_pix'(48'h00_ff_00_ff_00_ff));
        wait_drained();

        // mask output, extreme offset, slope and gain
        c             = RESET_CFG;
        c.mask_mode   = 1'b1;
        c.key_offset  = 21'h100000;
        c.key_cos     = 14'sd4096;
        c.key_sin     = -14'sd4096;
        c.wedge_slope = 16'hffff;
        c.alpha_gain  = 16'hffff;
        c.key_chroma  = 18'h3ffff;
        program_setting(c);
        send_pixel(t_pix'(48'h80_80_80_10_20_30));
        send_pixel(t_pix'(48'hff_00_ff_00_00_00));
        send_pixel(t_pix'(48'h00_ff_00_ff_ff_ff));
        send_pixel(t_pix'(48'h55_90_70_aa_aa_aa));
        wait_drained();

        // full alpha with capped spill, chroma clamped at both ends
        c             = RESET_CFG;
        c.key_offset  = 21'h0fffff;
        c.key_cos     = 14'sd4096;
        c.key_sin     = 14'sd0;
        c.wedge_slope = 16'h0000;
        c.alpha_gain  = 16'hffff;
        c.spill_gain  = 13'h1fff;
        c.key_chroma  = {9'h100, 9'h0ff};
        program_setting(c);
        send_pixel(t_pix'(48'hc8_ff_00_10_80_80));
        send_pixel(t_pix'(48'h40_81_80_f0_00_ff));
        send_pixel(t_pix'(48'h80_c8_3c_00_ff_00));
        send_pixel(t_pix'(48'hff_80_ff_00_00_00));
        send_pixel(t_pix'(48'h20_00_c0_ff_ff_ff));
        wait_drained();

        // rotation registers beyond unit range, small uncapped spill
        c             = RESET_CFG;
        c.key_offset  = 21'd300000;
        c.key_cos     = 14'h2000;
        c.key_sin     = 14'h1fff;
        c.spill_gain  = 13'd1;
        c.key_chroma  = {9'h1c0, 9'h040};
        program_setting(c);
        send_pixel(t_pix'(48'h90_00_ff_30_c0_40));
        send_pixel(t_pix'(48'h10_ff_00_e0_20_d0));
        send_pixel(t_pix'(48'h7f_81_7f_01_fe_80));
        send_pixel(t_pix'(48'hff_60_a0_00_ff_80));
        wait_drained();

        // zero gain leaves only background
        c             = RESET_CFG;
        c.key_offset  = 21'h0fffff;
        c.wedge_slope = 16'h0000;
        c.alpha_gain  = 16'h0000;
        program_setting(c);
        send_pixel(t_pix'(48'hff_ff_ff_00_00_00));
        send_pixel(t_pix'(48'h00_00_00_ff_ff_ff));

        // random key scenes, 55 percent of the foreground near the key colour
        for (phase = 0; phase < SCENES; phase++) begin
            wait_drained();
            tx_idle_pct = (phase < 2) ? 30 : ((phase < 4) ? 73 : 0);
            rx_idle_pct = (phase < 2) ? 73 : ((phase < 4) ? 30 : 0);
            do begin
                ku = int'($urandom_range(255)) - 128;
                kv = int'($urandom_range(255)) - 128;
            end while (ku * ku + kv * kv < 400);
            mag           = $sqrt(real'(ku * ku + kv * kv));
            c.key_cos     = 14'($rtoi(4096.0 * ku / mag));
            c.key_sin     = 14'($rtoi(4096.0 * kv / mag));
            c.key_offset  = 21'($rtoi((mag - real'($urandom_range(60, 10))) * 4096.0));
            c.wedge_slope = 16'($urandom_range(16384, 1024));
            c.alpha_gain  = 16'($urandom_range(8192, 256));
            c.spill_gain  = 13'($urandom_range(4096));
            c.key_chroma  = {9'(ku), 9'(kv)};
            c.mask_mode   = ($urandom_range(3) == 0);
            program_setting(c);
            // receiver holds off while items keep coming
            if (phase == SCENES - 1) begin
                rx_hold = HOLD_CYCLES;
            end
            for (n = 0; n < SCENE_ITEMS; n++) begin
                p = t_pix'({$urandom, 16'($urandom)});
                if ($urandom_range(99) < 55) begin
                    p.fg_cb = model.sat8(longint'(128 + ku + int'($urandom_range(80)) - 40));
                    p.fg_cr = model.sat8(longint'(128 + kv + int'($urandom_range(80)) - 40));
                end
                send_pixel(p);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items over %0d key settings: %0d mask, %0d background, %0d blended",
                 model.n_items, settings + 1, model.n_mask, model.n_bg, model.n_blend);
        $display("blends with spill removal %0d, mismatches %0d", model.n_spill,
                 model.mismatches);
        if (model.mismatches == 0 && model.expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
